/* rtl/saq_pkg.sv */
// saq_pkg: shared types, constants and latency helpers for the shortest-arc
// quaternion block. Depends on nothing; used by saq_norm and the top level.
`default_nettype none

package saq_pkg;

  localparam int INPUT_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 30;
  localparam int MARGIN_W        = 21;
  localparam int Q_W             = 32;
  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(1);

  // register stages of the normalizer ahead of the divider (squares, sum)
  localparam int NORM_PRE_STAGES = 2;

  typedef enum logic [1:0] {
    KIND_GENERAL  = 2'd0,
    KIND_PARALLEL = 2'd1,
    KIND_ANTI     = 2'd2,
    KIND_ZERO     = 2'd3
  } kind_t;

  // squares + sum, one stage per quotient bit, one stage per root bit
  function automatic int norm_latency(input int frac);
    return NORM_PRE_STAGES + (2 * frac + 1) + (frac + 1);
  endfunction

endpackage

`default_nettype wire

/* rtl/saq_norm.sv */
// saq_norm: pipelined vector normalizer, component = sign * isqrt(m^2*2^2F / |v|^2).
// Restoring divider one quotient bit per stage, then a digit-per-stage square root.
// Depends on saq_pkg.
`default_nettype none

module saq_norm import saq_pkg::*; #(
  parameter int VECS  = 2,
  parameter int LANES = 3,
  parameter int VW    = INPUT_WIDTH_DEF,
  parameter int FRAC  = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    in_valid,
  input  wire logic signed [VW-1:0]    in_vec [VECS*LANES],
  output logic                         out_valid,
  output logic signed [FRAC+1:0]       out_vec [VECS*LANES]
);

  localparam int N   = VECS * LANES;
  localparam int SQW = 2 * VW;
  localparam int SW  = SQW + $clog2(LANES + 1);
  localparam int RW  = SW + 1;
  localparam int QB  = 2 * FRAC + 1;
  localparam int DST = QB;
  localparam int SST = FRAC + 1;
  localparam int LAT = norm_latency(FRAC);
  localparam int UW  = FRAC + 2;

  logic [LAT-1:0] vld_r;
  logic           sgp_r [LAT][N];
  logic           zp_r  [1:LAT-1][VECS];

  logic [VW-1:0]  mag_nxt [N];
  logic [SQW-1:0] sq_r    [N];
  logic [SW-1:0]  s_nxt   [VECS];

  logic [RW-1:0]  rem_r [1:DST][N];
  logic [SW-1:0]  den_r [1:DST][VECS];
  logic [QB-1:0]  q_r   [2:1+DST][N];

  logic [QB-1:0]  sn_r  [2+DST:LAT-2][N];
  logic [QB-1:0]  sr_r  [2+DST:LAT-1][N];

  // valid, sign and zero-vector flags travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      mag_nxt[i] = in_vec[i][VW-1] ? VW'(-in_vec[i]) : VW'(in_vec[i]);
    end
    for (int v = 0; v < VECS; v++) begin
      s_nxt[v] = '0;
      for (int l = 0; l < LANES; l++) begin
        s_nxt[v] = s_nxt[v] + SW'(sq_r[v*LANES+l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N; i++) begin
        sq_r[i]     <= SQW'(mag_nxt[i]) * SQW'(mag_nxt[i]);
        sgp_r[0][i] <= in_vec[i][VW-1];
        rem_r[1][i] <= RW'(sq_r[i]);
        for (int k = 1; k < LAT; k++) begin
          sgp_r[k][i] <= sgp_r[k-1][i];
        end
      end
      for (int v = 0; v < VECS; v++) begin
        den_r[1][v] <= s_nxt[v];
        zp_r[1][v]  <= (s_nxt[v] == '0);
        for (int k = 2; k < LAT; k++) begin
          zp_r[k][v] <= zp_r[k-1][v];
        end
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DST; k++) begin : g_div
    for (genvar i = 0; i < N; i++) begin : g_ln
      logic [RW-1:0] t;
      logic          ge;
      if (k == 0) begin : g_first
        assign t = rem_r[1][i];
      end else begin : g_next
        assign t = {rem_r[1+k][i][RW-2:0], 1'b0};
      end
      assign ge = (t >= RW'(den_r[1+k][i/LANES]));

      if (k == 0) begin : g_q0
        always_ff @(posedge clk) begin
          if (en) q_r[2][i] <= QB'(ge);
        end
      end else begin : g_qn
        always_ff @(posedge clk) begin
          if (en) q_r[2+k][i] <= {q_r[1+k][i][QB-2:0], ge};
        end
      end

      if (k < DST - 1) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) rem_r[2+k][i] <= ge ? (t - RW'(den_r[1+k][i/LANES])) : t;
        end
      end
    end

    if (k < DST - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          for (int v = 0; v < VECS; v++) begin
            den_r[2+k][v] <= den_r[1+k][v];
          end
        end
      end
    end
  end

  // integer square root, one result bit per stage
  for (genvar j = 0; j < SST; j++) begin : g_sqrt
    localparam logic [QB-1:0] BIT = QB'(1) << (2 * (FRAC - j));
    for (genvar i = 0; i < N; i++) begin : g_ln
      logic [QB-1:0] n_src;
      logic [QB-1:0] r_src;
      logic [QB:0]   trial;
      logic          ge;
      if (j == 0) begin : g_first
        assign n_src = q_r[1+DST][i];
        assign r_src = '0;
      end else begin : g_next
        assign n_src = sn_r[1+DST+j][i];
        assign r_src = sr_r[1+DST+j][i];
      end
      assign trial = (QB+1)'(r_src) + (QB+1)'(BIT);
      assign ge    = ((QB+1)'(n_src) >= trial);

      always_ff @(posedge clk) begin
        if (en) sr_r[2+DST+j][i] <= ge ? ((r_src >> 1) + BIT) : (r_src >> 1);
      end
      if (j < SST - 1) begin : g_n
        always_ff @(posedge clk) begin
          if (en) sn_r[2+DST+j][i] <= ge ? (n_src - QB'(trial)) : n_src;
        end
      end
    end
  end

  assign out_valid = vld_r[LAT-1];

  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (zp_r[LAT-1][i/LANES]) begin
        out_vec[i] = '0;
      end else if (sgp_r[LAT-1][i]) begin
        out_vec[i] = -$signed(UW'(sr_r[LAT-1][i]));
      end else begin
        out_vec[i] = $signed(UW'(sr_r[LAT-1][i]));
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/shortest_arc_quaternion.sv */
// shortest_arc_quaternion: top level, unit quaternion of the shortest rotation
// between two integer 3-vectors. Depends on saq_pkg and saq_norm.
//
// One word is accepted per cycle while the output is not stalled, and results
// come out in order after passing through a normalizer for both input vectors,
// three stages for products, dot/cross and case selection, a second normalizer
// for the quaternion, and the output register. Each normalizer spends one stage
// per quotient bit of its divider and one per root bit, which sets the depth. A
// stalled output holds the whole pipeline; in_ready follows out_ready
// combinationally.
`default_nettype none

module shortest_arc_quaternion import saq_pkg::*; #(
  parameter int INPUT_WIDTH = INPUT_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [MARGIN_W-1:0]           cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [INPUT_WIDTH-1:0] in_from_x,
  input  wire logic signed [INPUT_WIDTH-1:0] in_from_y,
  input  wire logic signed [INPUT_WIDTH-1:0] in_from_z,
  input  wire logic signed [INPUT_WIDTH-1:0] in_to_x,
  input  wire logic signed [INPUT_WIDTH-1:0] in_to_y,
  input  wire logic signed [INPUT_WIDTH-1:0] in_to_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_valid_res,
  output logic [1:0]                         out_case_taken,
  output logic signed [Q_W-1:0]              out_q_x,
  output logic signed [Q_W-1:0]              out_q_y,
  output logic signed [Q_W-1:0]              out_q_z,
  output logic signed [Q_W-1:0]              out_q_w
);

  localparam int AW   = FRAC_BITS + 2;
  localparam int PW   = 2 * AW;
  localparam int SUMW = PW + 2;
  localparam int GW   = FRAC_BITS + 3;
  localparam int CW   = ((GW > MARGIN_W + 1) ? GW : MARGIN_W + 1) + 1;
  localparam int L2   = norm_latency(FRAC_BITS);
  localparam logic signed [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
  localparam logic signed [GW-1:0] ONE_G = GW'(1) << FRAC_BITS;

  logic                 en;
  logic [MARGIN_W-1:0]  margin_r;

  logic signed [INPUT_WIDTH-1:0] n1_in [6];
  logic                          n1_valid;
  logic signed [AW-1:0]          n1_vec [6];

  logic                 p1_v_r;
  logic signed [PW-1:0] pd_r [3];
  logic signed [PW-1:0] pc_r [6];
  logic signed [AW-1:0] p1_a_r [3];
  logic                 p1_zero_r;

  logic                 p2_v_r;
  logic signed [GW-1:0] p2_d_r;
  logic signed [GW-1:0] p2_c_r [3];
  logic signed [AW-1:0] p2_a_r [3];
  logic                 p2_zero_r;

  logic                 p3_v_r;
  kind_t                p3_kind_r;
  logic signed [GW-1:0] p3_g_r [4];

  kind_t                kind_nxt;
  logic signed [GW-1:0] g_nxt [4];
  logic [AW-1:0]        amag [3];
  logic [1:0]           basis;
  logic signed [CW-1:0] d_ext;
  logic signed [CW-1:0] marg_ext;

  logic                 n2_valid;
  logic signed [AW-1:0] n2_vec [4];
  kind_t                sb_r [L2];

  logic                 out_valid_r;

  function automatic logic signed [GW-1:0] tdiv(input logic signed [SUMW-1:0] x);
    logic signed [SUMW-1:0] m;
    m = x[SUMW-1] ? -x : x;
    m = m >>> FRAC_BITS;
    return GW'(x[SUMW-1] ? -m : m);
  endfunction

  assign en       = ~out_valid_r | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RST;
    end else if (cfg_wr_en) begin
      margin_r <= cfg_wr_data;
    end
  end

  assign n1_in[0] = in_from_x;
  assign n1_in[1] = in_from_y;
  assign n1_in[2] = in_from_z;
  assign n1_in[3] = in_to_x;
  assign n1_in[4] = in_to_y;
  assign n1_in[5] = in_to_z;

  saq_norm #(
    .VECS (2),
    .LANES(3),
    .VW   (INPUT_WIDTH),
    .FRAC (FRAC_BITS)
  ) u_norm_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_vec   (n1_in),
    .out_valid(n1_valid),
    .out_vec  (n1_vec)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= n1_valid;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  // products of unit vectors; a zero vector normalizes to all zeros
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pd_r[i]   <= PW'(n1_vec[i]) * PW'(n1_vec[3+i]);
        p1_a_r[i] <= n1_vec[i];
      end
      pc_r[0]   <= PW'(n1_vec[1]) * PW'(n1_vec[5]);
      pc_r[1]   <= PW'(n1_vec[2]) * PW'(n1_vec[4]);
      pc_r[2]   <= PW'(n1_vec[2]) * PW'(n1_vec[3]);
      pc_r[3]   <= PW'(n1_vec[0]) * PW'(n1_vec[5]);
      pc_r[4]   <= PW'(n1_vec[0]) * PW'(n1_vec[4]);
      pc_r[5]   <= PW'(n1_vec[1]) * PW'(n1_vec[3]);
      p1_zero_r <= (n1_vec[0] == '0 && n1_vec[1] == '0 && n1_vec[2] == '0) ||
                   (n1_vec[3] == '0 && n1_vec[4] == '0 && n1_vec[5] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_d_r    <= tdiv(SUMW'(pd_r[0]) + SUMW'(pd_r[1]) + SUMW'(pd_r[2]));
      p2_c_r[0] <= tdiv(SUMW'(pc_r[0]) - SUMW'(pc_r[1]));
      p2_c_r[1] <= tdiv(SUMW'(pc_r[2]) - SUMW'(pc_r[3]));
      p2_c_r[2] <= tdiv(SUMW'(pc_r[4]) - SUMW'(pc_r[5]));
      p2_a_r    <= p1_a_r;
      p2_zero_r <= p1_zero_r;
    end
  end

  // case selection and the 4-vector to normalize
  always_comb begin
    d_ext    = CW'(p2_d_r);
    marg_ext = $signed(CW'(margin_r));
    for (int i = 0; i < 3; i++) begin
      amag[i] = p2_a_r[i][AW-1] ? AW'(-p2_a_r[i]) : AW'(p2_a_r[i]);
    end
    basis = 2'd0;
    if (amag[1] < amag[0]) basis = 2'd1;
    if (amag[2] < amag[basis]) basis = 2'd2;

    for (int i = 0; i < 4; i++) g_nxt[i] = '0;
    if (p2_zero_r) begin
      kind_nxt = KIND_ZERO;
    end else if (d_ext > ONE_C - marg_ext) begin
      kind_nxt = KIND_PARALLEL;
    end else if (d_ext < -ONE_C + marg_ext) begin
      kind_nxt = KIND_ANTI;
      // half-turn axis: unit "from" crossed with its least-aligned axis
      case (basis)
        2'd0: begin
          g_nxt[1] = GW'(p2_a_r[2]);
          g_nxt[2] = -GW'(p2_a_r[1]);
        end
        2'd1: begin
          g_nxt[2] = GW'(p2_a_r[0]);
          g_nxt[0] = -GW'(p2_a_r[2]);
        end
        default: begin
          g_nxt[0] = GW'(p2_a_r[1]);
          g_nxt[1] = -GW'(p2_a_r[0]);
        end
      endcase
    end else begin
      kind_nxt = KIND_GENERAL;
      g_nxt[0] = p2_c_r[0];
      g_nxt[1] = p2_c_r[1];
      g_nxt[2] = p2_c_r[2];
      g_nxt[3] = ONE_G + p2_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_kind_r <= kind_nxt;
      p3_g_r    <= g_nxt;
    end
  end

  saq_norm #(
    .VECS (1),
    .LANES(4),
    .VW   (GW),
    .FRAC (FRAC_BITS)
  ) u_norm_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (p3_v_r),
    .in_vec   (p3_g_r),
    .out_valid(n2_valid),
    .out_vec  (n2_vec)
  );

  // case code rides alongside the second normalizer
  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= p3_kind_r;
      for (int k = 1; k < L2; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= n2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_case_taken <= sb_r[L2-1];
      out_valid_res  <= (sb_r[L2-1] != KIND_ZERO);
      case (sb_r[L2-1])
        KIND_ZERO: begin
          out_q_x <= '0;
          out_q_y <= '0;
          out_q_z <= '0;
          out_q_w <= '0;
        end
        KIND_PARALLEL: begin
          out_q_x <= '0;
          out_q_y <= '0;
          out_q_z <= '0;
          out_q_w <= Q_W'(ONE_G);
        end
        default: begin
          out_q_x <= Q_W'(n2_vec[0]);
          out_q_y <= Q_W'(n2_vec[1]);
          out_q_z <= Q_W'(n2_vec[2]);
          out_q_w <= Q_W'(n2_vec[3]);
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
